// ===== rtl/lgsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lgsm_pkg : shared types and constants of the loop gap and stall monitor
// Event codes, field widths, register indexes and the pipeline control word.
// ----------------------------------------------------------------------------
package lgsm_pkg;

  // event codes
  typedef enum logic [1:0] {
    FUNC_MARK  = 2'd0,
    FUNC_SKIP  = 2'd1,
    FUNC_BEGIN = 2'd2,
    FUNC_END   = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WINDOW     = 2'd0,
    REG_STALL_LOW  = 2'd1,
    REG_STALL_HIGH = 2'd2,
    REG_SLOW_SECT  = 2'd3
  } reg_idx_t;

  localparam int SECTIONS_DEF = 5;
  localparam int SKIP_SECTION = 2;

  localparam int TS_W   = 32;   // timestamp width
  localparam int MS_W   = 23;   // millisecond gap width
  localparam int CNT_W  = 32;   // stall counter width
  localparam int SEC_W  = 3;    // section field width
  localparam int FUNC_W = 2;
  localparam int CFG_W  = 32;

  // floor(x / 1000) for 32-bit x equals (x * RECIP_1000) >> RECIP_SHIFT
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

  localparam logic [CFG_W-1:0] WINDOW_RST     = 32'd10000;
  localparam logic [MS_W-1:0]  STALL_LOW_RST  = 23'd50;
  localparam logic [MS_W-1:0]  STALL_HIGH_RST = 23'd250;
  localparam logic [MS_W-1:0]  SLOW_SECT_RST  = 23'd100;

  // control word that travels with each transaction down the pipeline
  typedef struct packed {
    func_t             func;
    logic [SEC_W-1:0]  section;
    logic              sec_ok;
    logic              gap_ok;
    logic              rotate;
  } ctrl_t;

endpackage

// ===== rtl/lgsm_div1000.sv =====
// ----------------------------------------------------------------------------
// lgsm_div1000 : microsecond to millisecond conversion stage
// One registered pipeline stage that divides a 32-bit difference by 1000
// through a reciprocal multiply, carrying the control word alongside.
// ----------------------------------------------------------------------------
module lgsm_div1000 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,        // stage loads when high
  input  logic                              in_valid,
  input  logic [lgsm_pkg::TS_W-1:0]         in_diff,
  input  lgsm_pkg::ctrl_t                   in_ctrl,
  output logic                              out_valid,
  output logic [lgsm_pkg::MS_W-1:0]         out_quot,
  output lgsm_pkg::ctrl_t                   out_ctrl
);

  localparam int PROD_W = lgsm_pkg::TS_W + lgsm_pkg::RECIP_W;

  logic [PROD_W-1:0]         prod;
  logic                      valid_r;
  logic [lgsm_pkg::MS_W-1:0] quot_r;
  lgsm_pkg::ctrl_t           ctrl_r;

  // reciprocal multiply, quotient is the top bits
  assign prod = PROD_W'(in_diff) * PROD_W'(lgsm_pkg::RECIP_1000);

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      quot_r <= prod[lgsm_pkg::RECIP_SHIFT +: lgsm_pkg::MS_W];
      ctrl_r <= in_ctrl;
    end
  end

  assign out_valid = valid_r;
  assign out_quot  = quot_r;
  assign out_ctrl  = ctrl_r;

endmodule

// ===== rtl/loop_gap_stall_monitor_top.sv =====
// ----------------------------------------------------------------------------
// loop_gap_stall_monitor_top : loop gap and stall monitor
// Times loop marks and code sections from event timestamps and reports
// window maxima, all-time peak and stall counters for every event.
// ----------------------------------------------------------------------------
// One event is taken per clock while the output side is not stalled, and each
// event gives exactly one result. The stage 1 register takes the microsecond
// difference while the mark, section start and window timers update, the
// divider stage divides by 1000 through the reciprocal multiplier, and the
// last stage folds the gap or duration into the maxima and counters and loads
// the output register. Results reflect the state after the event's own
// update. Configuration registers should only be written while no transaction
// is in flight.
module loop_gap_stall_monitor_top #(
  parameter int SECTIONS = lgsm_pkg::SECTIONS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // section[2:0], now_us[34:3], now_ms[66:35], zero fill
  input  logic [1:0]   in_tuser,   // func[1:0]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // recent_max_ms[22:0], peak_gap_ms[45:23],
                                   // low_stall_count[77:46], high_stall_count[109:78],
                                   // section_recent_max_ms[132:110], zero fill
  output logic         out_tuser,  // slow_flag
  // configuration
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int TS_W  = lgsm_pkg::TS_W;
  localparam int MS_W  = lgsm_pkg::MS_W;
  localparam int CNT_W = lgsm_pkg::CNT_W;
  localparam int SEC_W = lgsm_pkg::SEC_W;
  localparam int SEC_IW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int SKIP  = lgsm_pkg::SKIP_SECTION;
  localparam bit SKIP_EN = (SKIP < SECTIONS);
  localparam int OUT_USED = 3 * MS_W + 2 * CNT_W;

  // input fields
  lgsm_pkg::func_t  in_func;
  logic [SEC_W-1:0] in_sec;
  logic [TS_W-1:0]  in_us;
  logic [TS_W-1:0]  in_ms;

  assign in_func = lgsm_pkg::func_t'(in_tuser);
  assign in_sec  = in_tdata[SEC_W-1:0];
  assign in_us   = in_tdata[SEC_W +: TS_W];
  assign in_ms   = in_tdata[SEC_W+TS_W +: TS_W];

  // configuration registers
  logic [TS_W-1:0] window_ms_r;
  logic [MS_W-1:0] stall_low_r;
  logic [MS_W-1:0] stall_high_r;
  logic [MS_W-1:0] slow_sect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r  <= lgsm_pkg::WINDOW_RST;
      stall_low_r  <= lgsm_pkg::STALL_LOW_RST;
      stall_high_r <= lgsm_pkg::STALL_HIGH_RST;
      slow_sect_r  <= lgsm_pkg::SLOW_SECT_RST;
    end else if (cfg_wr_en) begin
      unique case (lgsm_pkg::reg_idx_t'(cfg_index))
        lgsm_pkg::REG_WINDOW:     window_ms_r  <= cfg_data;
        lgsm_pkg::REG_STALL_LOW:  stall_low_r  <= cfg_data[MS_W-1:0];
        lgsm_pkg::REG_STALL_HIGH: stall_high_r <= cfg_data[MS_W-1:0];
        lgsm_pkg::REG_SLOW_SECT:  slow_sect_r  <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control, nothing is taken while in reset
  logic s1_valid_r;
  logic s2_valid;
  logic out_valid_r;
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic accept;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_free   = !s2_valid || out_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_tready = s1_free && rst_n;
  assign accept    = in_tvalid && in_tready;

  // front-end timer state
  logic [TS_W-1:0] last_mark_us_r;
  logic            last_valid_r;
  logic [TS_W-1:0] win_start_r;
  logic [TS_W-1:0] sect_start_r [SECTIONS];

  logic              in_sec_ok;
  logic [SEC_IW-1:0] in_idx;
  logic [TS_W-1:0]   ref_us;
  logic              win_due;
  lgsm_pkg::ctrl_t   in_ctrl;

  assign in_sec_ok = (32'(in_sec) < 32'(SECTIONS));
  assign in_idx    = in_sec_ok ? SEC_IW'(in_sec) : '0;
  assign ref_us    = (in_func == lgsm_pkg::FUNC_MARK) ? last_mark_us_r : sect_start_r[in_idx];
  assign win_due   = (in_ms - win_start_r) >= window_ms_r;

  always_comb begin
    in_ctrl.func    = in_func;
    in_ctrl.section = in_sec;
    in_ctrl.sec_ok  = in_sec_ok;
    in_ctrl.gap_ok  = (in_func == lgsm_pkg::FUNC_MARK) && last_valid_r;
    in_ctrl.rotate  = (in_func == lgsm_pkg::FUNC_MARK) && win_due;
  end

  // mark and window timers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mark_us_r <= '0;
      last_valid_r   <= 1'b0;
      win_start_r    <= '0;
    end else if (accept) begin
      unique case (in_func)
        lgsm_pkg::FUNC_MARK: begin
          last_mark_us_r <= in_us;
          last_valid_r   <= 1'b1;
          if (win_due) begin
            win_start_r <= in_ms;
          end
        end
        lgsm_pkg::FUNC_SKIP: begin
          last_valid_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // section start times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS; i++) begin
        sect_start_r[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < SECTIONS; i++) begin
        if (in_func == lgsm_pkg::FUNC_BEGIN && in_sec_ok && in_idx == SEC_IW'(i)) begin
          sect_start_r[i] <= in_us;
        end else if (in_func == lgsm_pkg::FUNC_SKIP && SKIP_EN && i == SKIP) begin
          sect_start_r[i] <= in_us;
        end
      end
    end
  end

  // stage 1 register: difference and control
  logic [TS_W-1:0] s1_diff_r;
  lgsm_pkg::ctrl_t s1_ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_diff_r <= in_us - ref_us;
      s1_ctrl_r <= in_ctrl;
    end
  end

  // stage 2: divide by 1000
  logic [MS_W-1:0] q;
  lgsm_pkg::ctrl_t s2_ctrl;

  lgsm_div1000 u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s2_free),
    .in_valid  (s1_valid_r),
    .in_diff   (s1_diff_r),
    .in_ctrl   (s1_ctrl_r),
    .out_valid (s2_valid),
    .out_quot  (q),
    .out_ctrl  (s2_ctrl)
  );

  // statistics state
  logic [MS_W-1:0]  gcur_r, gprev_r, peak_r;
  logic [CNT_W-1:0] low_cnt_r, high_cnt_r;
  logic [MS_W-1:0]  scur_r  [SECTIONS];
  logic [MS_W-1:0]  sprev_r [SECTIONS];

  logic [MS_W-1:0]  gcur_f, gcur_nxt, gprev_nxt, peak_nxt;
  logic [CNT_W-1:0] low_cnt_nxt, high_cnt_nxt;
  logic [MS_W-1:0]  scur_nxt  [SECTIONS];
  logic [MS_W-1:0]  sprev_nxt [SECTIONS];
  logic [MS_W-1:0]  sfold;
  logic             end_hit;
  logic [SEC_IW-1:0] s2_idx;
  logic [MS_W-1:0]  recent_nxt, sec_recent_nxt;
  logic             slow_nxt;
  logic             s2_fire;

  assign s2_fire = s2_valid && out_free;
  assign s2_idx  = s2_ctrl.sec_ok ? SEC_IW'(s2_ctrl.section) : '0;
  assign end_hit = (s2_ctrl.func == lgsm_pkg::FUNC_END) && s2_ctrl.sec_ok;

  // fold gap into loop statistics, then rotate the window
  always_comb begin
    gcur_f    = (s2_ctrl.gap_ok && q > gcur_r) ? q : gcur_r;
    gcur_nxt  = s2_ctrl.rotate ? '0 : gcur_f;
    gprev_nxt = s2_ctrl.rotate ? gcur_f : gprev_r;
    peak_nxt  = (s2_ctrl.gap_ok && q > peak_r) ? q : peak_r;
    low_cnt_nxt  = low_cnt_r + CNT_W'(s2_ctrl.gap_ok && q > stall_low_r);
    high_cnt_nxt = high_cnt_r + CNT_W'(s2_ctrl.gap_ok && q > stall_high_r);
    recent_nxt   = (gcur_nxt > gprev_nxt) ? gcur_nxt : gprev_nxt;
  end

  // fold section duration, rotate section maxima
  always_comb begin
    for (int i = 0; i < SECTIONS; i++) begin
      sfold = (end_hit && s2_idx == SEC_IW'(i) && q > scur_r[i]) ? q : scur_r[i];
      scur_nxt[i]  = s2_ctrl.rotate ? '0 : sfold;
      sprev_nxt[i] = s2_ctrl.rotate ? sfold : sprev_r[i];
    end
    if (s2_ctrl.sec_ok) begin
      sec_recent_nxt = (scur_nxt[s2_idx] > sprev_nxt[s2_idx]) ?
                       scur_nxt[s2_idx] : sprev_nxt[s2_idx];
    end else begin
      sec_recent_nxt = '0;
    end
    slow_nxt = end_hit && (q > slow_sect_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcur_r     <= '0;
      gprev_r    <= '0;
      peak_r     <= '0;
      low_cnt_r  <= '0;
      high_cnt_r <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        scur_r[i]  <= '0;
        sprev_r[i] <= '0;
      end
    end else if (s2_fire) begin
      gcur_r     <= gcur_nxt;
      gprev_r    <= gprev_nxt;
      peak_r     <= peak_nxt;
      low_cnt_r  <= low_cnt_nxt;
      high_cnt_r <= high_cnt_nxt;
      for (int i = 0; i < SECTIONS; i++) begin
        scur_r[i]  <= scur_nxt[i];
        sprev_r[i] <= sprev_nxt[i];
      end
    end
  end

  // result register
  logic [135:0] out_data_r;
  logic         out_slow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_data_r <= {(136 - OUT_USED)'(0), sec_recent_nxt, high_cnt_nxt, low_cnt_nxt,
                     peak_nxt, recent_nxt};
      out_slow_r <= slow_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_slow_r;

endmodule

// ===== tb/loop_gap_stall_monitor_top_test.sv =====
// ----------------------------------------------------------------------------
// loop_gap_stall_monitor_top_test : self-checking bench for the loop monitor
// Drives mark, skip, section begin and section end events through the input
// stream and predicts every report from a behavioural copy of the monitor
// state. Reports are checked field by field in order. The run covers directed
// corner cases, register extremes, several random window and threshold
// settings with random idle and stall bursts, and a closing stretch at full
// rate with no gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module loop_gap_stall_monitor_top_test;

  localparam int NUM_SECTIONS = lgsm_pkg::SECTIONS_DEF;
  localparam int US_PER_MS    = 1000;
  localparam int HANG_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TS_W  = lgsm_pkg::TS_W;
  localparam int MS_W  = lgsm_pkg::MS_W;
  localparam int CNT_W = lgsm_pkg::CNT_W;
  localparam int SEC_W = lgsm_pkg::SEC_W;

  // one report as the monitor should produce it
  typedef struct packed {
    logic [MS_W-1:0]  recent_max;
    logic [MS_W-1:0]  peak;
    logic [CNT_W-1:0] low_count;
    logic [CNT_W-1:0] high_count;
    logic [MS_W-1:0]  sect_recent;
    logic             slow;
  } report_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;    // section[2:0], now_us[34:3], now_ms[66:35], zero fill
  logic [1:0]   in_tuser = '0;    // func[1:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;        // recent_max_ms[22:0], peak_gap_ms[45:23],
                                  // low_stall_count[77:46], high_stall_count[109:78],
                                  // section_recent_max_ms[132:110], zero fill
  logic         out_tuser;        // slow_flag
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // predicted monitor settings and state
  logic [TS_W-1:0]  win_len_ms;
  logic [MS_W-1:0]  low_limit_ms;
  logic [MS_W-1:0]  high_limit_ms;
  logic [MS_W-1:0]  slow_limit_ms;
  logic [TS_W-1:0]  mark_us;
  logic             mark_valid;
  logic [TS_W-1:0]  win_start_ms;
  logic [MS_W-1:0]  gap_cur;
  logic [MS_W-1:0]  gap_prev;
  logic [MS_W-1:0]  gap_peak;
  logic [CNT_W-1:0] low_stalls;
  logic [CNT_W-1:0] high_stalls;
  logic [TS_W-1:0]  sect_start_us [NUM_SECTIONS];
  logic [MS_W-1:0]  sect_cur [NUM_SECTIONS];
  logic [MS_W-1:0]  sect_prev [NUM_SECTIONS];

  report_t expected_reports [$];

  // free-running timebase used to build plausible event sequences
  logic [TS_W-1:0] clock_us;
  logic [TS_W-1:0] clock_ms;

  bit gaps_on = 1'b1;
  int unsigned ready_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned failures = 0;
  int unsigned events_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned rollovers = 0;
  int unsigned slow_sections = 0;
  int unsigned settings_loaded = 0;

  loop_gap_stall_monitor_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // state after reset
  function automatic void clear_monitor_state();
    win_len_ms    = lgsm_pkg::WINDOW_RST;
    low_limit_ms  = lgsm_pkg::STALL_LOW_RST;
    high_limit_ms = lgsm_pkg::STALL_HIGH_RST;
    slow_limit_ms = lgsm_pkg::SLOW_SECT_RST;
    mark_us       = '0;
    mark_valid    = 1'b0;
    win_start_ms  = '0;
    gap_cur       = '0;
    gap_prev      = '0;
    gap_peak      = '0;
    low_stalls    = '0;
    high_stalls   = '0;
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      sect_start_us[i] = '0;
      sect_cur[i]      = '0;
      sect_prev[i]     = '0;
    end
  endfunction

  // apply one event to the predicted state and form its report
  function automatic report_t apply_event(lgsm_pkg::func_t kind, logic [SEC_W-1:0] sec,
                                          logic [TS_W-1:0] now_us,
                                          logic [TS_W-1:0] now_ms);
    report_t rep;
    logic [TS_W-1:0] span_ms;
    logic sec_ok;
    rep = '0;
    sec_ok = (sec < NUM_SECTIONS);
    case (kind)
      lgsm_pkg::FUNC_MARK: begin
        if (mark_valid) begin
          span_ms = (now_us - mark_us) / US_PER_MS;
          if (span_ms > gap_cur) gap_cur = span_ms[MS_W-1:0];
          if (span_ms > gap_peak) gap_peak = span_ms[MS_W-1:0];
          if (span_ms > low_limit_ms) low_stalls = low_stalls + 1;
          if (span_ms > high_limit_ms) high_stalls = high_stalls + 1;
        end
        mark_us = now_us;
        mark_valid = 1'b1;
        // window rollover moves current maxima to previous
        if (now_ms - win_start_ms >= win_len_ms) begin
          win_start_ms = now_ms;
          gap_prev = gap_cur;
          gap_cur = '0;
          for (int i = 0; i < NUM_SECTIONS; i++) begin
            sect_prev[i] = sect_cur[i];
            sect_cur[i] = '0;
          end
          rollovers++;
        end
      end
      lgsm_pkg::FUNC_SKIP: begin
        mark_valid = 1'b0;
        if (lgsm_pkg::SKIP_SECTION < NUM_SECTIONS)
          sect_start_us[lgsm_pkg::SKIP_SECTION] = now_us;
      end
      lgsm_pkg::FUNC_BEGIN: begin
        if (sec_ok) sect_start_us[sec] = now_us;
      end
      default: begin
        if (sec_ok) begin
          span_ms = (now_us - sect_start_us[sec]) / US_PER_MS;
          if (span_ms > sect_cur[sec]) sect_cur[sec] = span_ms[MS_W-1:0];
          if (span_ms > slow_limit_ms) begin
            rep.slow = 1'b1;
            slow_sections++;
          end
        end
      end
    endcase
    if (sec_ok)
      rep.sect_recent = (sect_cur[sec] > sect_prev[sec]) ? sect_cur[sec] : sect_prev[sec];
    rep.recent_max = (gap_cur > gap_prev) ? gap_cur : gap_prev;
    rep.peak       = gap_peak;
    rep.low_count  = low_stalls;
    rep.high_count = high_stalls;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // predict on each accepted event, check each accepted report
  always @(posedge clk) begin : report_check
    report_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_reports.push_back(apply_event(lgsm_pkg::func_t'(in_tuser), in_tdata[2:0],
                                               in_tdata[34:3], in_tdata[66:35]));
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("report with nothing expected: %0h slow %0b", out_tdata, out_tuser);
        end else begin
          want = expected_reports.pop_front();
          check_field("recent_max_ms", 32'(want.recent_max), 32'(out_tdata[22:0]));
          check_field("peak_gap_ms", 32'(want.peak), 32'(out_tdata[45:23]));
          check_field("low_stall_count", want.low_count, out_tdata[77:46]);
          check_field("high_stall_count", want.high_count, out_tdata[109:78]);
          check_field("section_recent_max_ms", 32'(want.sect_recent),
                      32'(out_tdata[132:110]));
          check_field("slow_flag", 32'(want.slow), 32'(out_tuser));
          reports_checked++;
        end
      end
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // hang detection: too long without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", idle_cycles);
      $display("FAIL loop_gap_stall_monitor_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // send one event; called and returns at a falling edge
  task automatic send_event(lgsm_pkg::func_t kind, logic [SEC_W-1:0] sec,
                            logic [TS_W-1:0] now_us, logic [TS_W-1:0] now_ms);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, now_ms, now_us, sec};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  // hold off input until every report is back, then let the pipeline settle
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(lgsm_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // write all four registers while the monitor is idle
  task automatic load_settings(logic [31:0] win, logic [MS_W-1:0] lo,
                               logic [MS_W-1:0] hi, logic [MS_W-1:0] slow);
    drain_reports();
    write_register(lgsm_pkg::REG_WINDOW, win);
    write_register(lgsm_pkg::REG_STALL_LOW, {9'b0, lo});
    write_register(lgsm_pkg::REG_STALL_HIGH, {9'b0, hi});
    write_register(lgsm_pkg::REG_SLOW_SECT, {9'b0, slow});
    win_len_ms    = win;
    low_limit_ms  = lo;
    high_limit_ms = hi;
    slow_limit_ms = slow;
    settings_loaded++;
  endtask

  function automatic logic [SEC_W-1:0] choose_section();
    if ($urandom_range(0, 7) == 0) return SEC_W'($urandom_range(NUM_SECTIONS, 7));
    return SEC_W'($urandom_range(0, NUM_SECTIONS - 1));
  endfunction

  // move the timebase forward, now and then by a long jump
  function automatic void advance_timebase(int unsigned span_ms);
    int unsigned step_us;
    if ($urandom_range(0, 19) == 0) step_us = $urandom_range(0, 30_000_000);
    else step_us = $urandom_range(0, span_ms * US_PER_MS + 999);
    clock_us = clock_us + step_us;
    clock_ms = clock_ms + step_us / US_PER_MS + $urandom_range(0, 1);
  endfunction

  // mostly well-formed mark and section sequences, some raw noise
  task automatic run_activity(int unsigned count, int unsigned span_ms);
    int unsigned sent_here;
    int unsigned pick;
    logic [SEC_W-1:0] sec;
    sent_here = 0;
    while (sent_here < count) begin
      pick = $urandom_range(0, 99);
      sec = choose_section();
      if (pick < 10) begin
        send_event(lgsm_pkg::func_t'($urandom_range(0, 3)), SEC_W'($urandom_range(0, 7)),
                   $urandom, $urandom);
        sent_here += 1;
      end else if (pick < 55) begin
        advance_timebase(span_ms);
        send_event(lgsm_pkg::FUNC_MARK, sec, clock_us, clock_ms);
        sent_here += 1;
      end else if (pick < 63) begin
        advance_timebase(span_ms / 4);
        send_event(lgsm_pkg::FUNC_SKIP, sec, clock_us, clock_ms);
        advance_timebase(span_ms);
        send_event(lgsm_pkg::FUNC_MARK, sec, clock_us, clock_ms);
        sent_here += 2;
      end else if (pick < 92) begin
        advance_timebase(span_ms / 4);
        send_event(lgsm_pkg::FUNC_BEGIN, sec, clock_us, clock_ms);
        advance_timebase(span_ms);
        send_event(lgsm_pkg::FUNC_END, sec, clock_us, clock_ms);
        sent_here += 2;
      end else begin
        // end with no matching begin
        advance_timebase(span_ms);
        send_event(lgsm_pkg::FUNC_END, sec, clock_us, clock_ms);
        sent_here += 1;
      end
    end
  endtask

  // corner cases under reset settings
  task automatic test_directed_events();
    send_event(lgsm_pkg::FUNC_END, 3'd1, 32'd500_000, 32'd500);     // end without begin
    send_event(lgsm_pkg::FUNC_MARK, 3'd0, 32'd0, 32'd0);            // first mark, time zero
    send_event(lgsm_pkg::FUNC_MARK, 3'd0, 32'd40_000, 32'd40);
    send_event(lgsm_pkg::FUNC_MARK, 3'd1, 32'd100_999, 32'd100);    // low stall only
    send_event(lgsm_pkg::FUNC_MARK, 3'd2, 32'd400_999, 32'd400);    // low and high stall
    send_event(lgsm_pkg::FUNC_SKIP, 3'd2, 32'd500_000, 32'd500);    // restarts section 2
    send_event(lgsm_pkg::FUNC_END, 3'd2, 32'd650_000, 32'd650);
    send_event(lgsm_pkg::FUNC_MARK, 3'd0, 32'd900_000, 32'd900);    // no gap after skip
    send_event(lgsm_pkg::FUNC_BEGIN, 3'd0, 32'hFFFE_7960, 32'hFFFF_FF9C);
    send_event(lgsm_pkg::FUNC_END, 3'd0, 32'd20_000, 32'd20);       // duration across wrap
    send_event(lgsm_pkg::FUNC_BEGIN, 3'd4, 32'd1_000_000, 32'd1000);
    send_event(lgsm_pkg::FUNC_END, 3'd4, 32'd1_100_000, 32'd1100);  // exactly at slow limit
    send_event(lgsm_pkg::FUNC_BEGIN, 3'd5, 32'd1_200_000, 32'd1200); // section out of range
    send_event(lgsm_pkg::FUNC_END, 3'd7, 32'd1_300_000, 32'd1300);
    send_event(lgsm_pkg::FUNC_BEGIN, 3'd6, 32'd1_300_000, 32'd1300);
    send_event(lgsm_pkg::FUNC_MARK, 3'd4, 32'd950_000, 32'd10_900); // window rollover
    send_event(lgsm_pkg::FUNC_MARK, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(lgsm_pkg::FUNC_SKIP, 3'd7, 32'h5555_5555, 32'hAAAA_AAAA);
    send_event(lgsm_pkg::FUNC_END, 3'd2, 32'hAAAA_AAAA, 32'h5555_5555);
    send_event(lgsm_pkg::FUNC_MARK, 3'd3, 32'd0, 32'd0);
  endtask

  // zero and full-scale register values
  task automatic test_register_extremes();
    load_settings(32'd0, '0, '0, '0);                        // every mark rolls over
    send_event(lgsm_pkg::FUNC_MARK, 3'd0, 32'd1000, 32'd5);
    send_event(lgsm_pkg::FUNC_MARK, 3'd1, 32'd2000, 32'd5);
    send_event(lgsm_pkg::FUNC_BEGIN, 3'd3, 32'd2000, 32'd5);
    send_event(lgsm_pkg::FUNC_END, 3'd3, 32'd2999, 32'd5);
    send_event(lgsm_pkg::FUNC_END, 3'd3, 32'd3000, 32'd5);
    send_event(lgsm_pkg::FUNC_MARK, 3'd3, 32'd3000, 32'd5);
    load_settings(32'hFFFF_FFFF, 23'd4294966, 23'd4294967, 23'd4294967);
    send_event(lgsm_pkg::FUNC_MARK, 3'd0, 32'd0, 32'd0);
    send_event(lgsm_pkg::FUNC_MARK, 3'd1, 32'hFFFF_FFFF, 32'd4);  // largest gap, rollover
    send_event(lgsm_pkg::FUNC_BEGIN, 3'd1, 32'd1, 32'd4);
    send_event(lgsm_pkg::FUNC_END, 3'd1, 32'd0, 32'd4);           // largest duration
    send_event(lgsm_pkg::FUNC_MARK, 3'd1, 32'hFFFF_FFFF, 32'd4);
  endtask

  // random settings per phase, with gaps on both sides
  task automatic test_random_settings();
    logic [MS_W-1:0] lo;
    for (int phase = 0; phase < 4; phase++) begin
      lo = MS_W'($urandom_range(0, 200));
      load_settings((phase == 1) ? 32'd1 : $urandom_range(1, 3000), lo,
                    MS_W'(lo + $urandom_range(0, 300)), MS_W'($urandom_range(0, 300)));
      clock_us = $urandom;
      clock_ms = $urandom;
      if (phase == 2) begin
        run_activity(60, 400);
        drain_reports();
        run_activity(60, 400);
      end else begin
        run_activity(120, 400);
      end
    end
  endtask

  // closing stretch at full rate
  task automatic test_full_rate();
    gaps_on = 1'b0;
    load_settings(32'd700, lgsm_pkg::STALL_LOW_RST, lgsm_pkg::STALL_HIGH_RST,
                  lgsm_pkg::SLOW_SECT_RST);
    run_activity(140, 300);
  endtask

  initial begin
    clear_monitor_state();
    clock_us = '0;
    clock_ms = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_events();
    test_register_extremes();
    test_random_settings();
    test_full_rate();

    drain_reports();
    repeat (8) @(posedge clk);
    $display("%0d events and %0d reports checked over %0d register settings",
             events_sent, reports_checked, settings_loaded);
    $display("%0d window rollovers and %0d slow sections predicted", rollovers, slow_sections);
    if (failures == 0) begin
      $display("PASS loop_gap_stall_monitor_top");
    end else begin
      $display("%0d mismatches in total", failures);
      $display("FAIL loop_gap_stall_monitor_top");
    end
    $finish;
  end

endmodule
